// ===== rtl/core/tcce_pkg.sv =====
package tcce_pkg;

  // Screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_STOP   = 8;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int COPY_CELLS = (ROWS - 1) * COLUMNS;

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = 11;
  localparam int CELL_W = 16;
  localparam int ATTR_W = 8;
  localparam int CHAR_W = 8;
  localparam int MODE_W = 2;

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_BS       = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF       = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'h7F;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUT   = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_READ  = 2'd2
  } mode_e;

  // Controller -> datapath
  typedef struct packed {
    logic accept;    // item transfer this cycle
    logic rd_load;   // read data is on the RAM port, load result
    logic copy;      // scroll copy step
    logic fill;      // blank fill step
    logic walk_clr;
    logic walk_inc;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic item_clear;
    logic item_scroll;
    logic item_read;
    logic copy_done;
    logic fill_done;
    logic out_busy;
  } status_t;

endpackage

// ===== rtl/core/tcce_req_if.sv =====
interface tcce_req_if;
  logic                             valid;
  logic                             ready;
  logic [tcce_pkg::MODE_W-1:0]      mode;
  logic [tcce_pkg::CHAR_W-1:0]      character;
  logic [tcce_pkg::ADDR_W-1:0]      read_address;

  modport source (output valid, output mode, output character, output read_address,
                  input ready);
  modport sink   (input valid, input mode, input character, input read_address,
                  output ready);
endinterface

// ===== rtl/core/tcce_rsp_if.sv =====
interface tcce_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [tcce_pkg::ADDR_W-1:0]      cursor_location;
  logic [tcce_pkg::CELL_W-1:0]      read_data;

  modport source (output valid, output cursor_location, output read_data, input ready);
  modport sink   (input valid, input cursor_location, input read_data, output ready);
endinterface

// ===== rtl/core/tcce_ram.sv =====
module tcce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/tcce_datapath.sv =====
module tcce_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tcce_pkg::ATTR_W-1:0]   cfg_wdata_i,
  input  logic [tcce_pkg::MODE_W-1:0]   mode_i,
  input  logic [tcce_pkg::CHAR_W-1:0]   character_i,
  input  logic [tcce_pkg::ADDR_W-1:0]   read_address_i,
  input  logic                          out_ready_i,
  input  tcce_pkg::cmd_t                cmd_i,
  output tcce_pkg::status_t             status_o,
  output logic                          out_valid_o,
  output logic [tcce_pkg::ADDR_W-1:0]   cursor_location_o,
  output logic [tcce_pkg::CELL_W-1:0]   read_data_o
);

  localparam int CW = tcce_pkg::COL_W + 1;
  localparam int RW = tcce_pkg::ROW_W + 1;
  localparam int AW = tcce_pkg::ADDR_W;

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] row,
                                              input logic [CW-1:0] col);
    logic [AW-1:0] base;
    base = AW'(AW'(row) * AW'(tcce_pkg::COLUMNS));
    return AW'(base + AW'(col));
  endfunction

  logic [tcce_pkg::COL_W-1:0]  col_q;
  logic [tcce_pkg::ROW_W-1:0]  row_q;
  logic [tcce_pkg::ATTR_W-1:0] attr_q;
  logic [AW-1:0]               walk_q;
  logic                        pend_q;
  logic [AW-1:0]               pend_addr_q;
  logic                        rd_ok_q;
  logic                        out_valid_q;
  logic [AW-1:0]               out_cursor_q;
  logic [tcce_pkg::CELL_W-1:0] out_data_q;

  logic [CW-1:0] col_x;
  logic [RW-1:0] row_x;
  logic          put_print;
  logic          scroll;
  logic          is_put;
  logic          is_read;
  logic          rd_ok;
  logic          copy_rd;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [tcce_pkg::CELL_W-1:0] ram_wdata;
  logic                        ram_re;
  logic [AW-1:0]               ram_raddr;
  logic [tcce_pkg::CELL_W-1:0] ram_rdata;

  assign is_put  = (mode_i == tcce_pkg::MODE_PUT);
  assign is_read = (mode_i == tcce_pkg::MODE_READ);
  assign rd_ok   = (read_address_i < AW'(tcce_pkg::CELL_COUNT));

  // Next cursor for the item on the request channel
  always_comb begin
    col_x     = CW'(col_q);
    row_x     = RW'(row_q);
    put_print = 1'b0;
    scroll    = 1'b0;
    if (is_put) begin
      case (character_i)
        tcce_pkg::CH_BS: begin
          if (col_q != '0) begin
            col_x = col_x - CW'(1);
          end
        end
        tcce_pkg::CH_TAB: begin
          col_x = CW'(col_x - col_x % tcce_pkg::TAB_STOP + tcce_pkg::TAB_STOP);
        end
        tcce_pkg::CH_CR: begin
          col_x = '0;
        end
        tcce_pkg::CH_LF: begin
          col_x = '0;
          row_x = row_x + RW'(1);
        end
        default: begin
          if (character_i >= tcce_pkg::CH_PRINT_LO && character_i <= tcce_pkg::CH_PRINT_HI) begin
            put_print = 1'b1;
            col_x     = col_x + CW'(1);
          end
        end
      endcase
      if (col_x >= CW'(tcce_pkg::COLUMNS)) begin
        col_x = '0;
        row_x = row_x + RW'(1);
      end
      if (row_x >= RW'(tcce_pkg::ROWS)) begin
        scroll = 1'b1;
        row_x  = RW'(tcce_pkg::ROWS - 1);
      end
    end else if (mode_i == tcce_pkg::MODE_CLEAR) begin
      col_x = '0;
      row_x = '0;
    end
  end

  // Cursor and attribute
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      attr_q <= tcce_pkg::ATTR_RESET;
    end else begin
      if (cfg_we_i) begin
        attr_q <= cfg_wdata_i;
      end
      if (cmd_i.accept) begin
        col_q <= tcce_pkg::COL_W'(col_x);
        row_q <= tcce_pkg::ROW_W'(row_x);
      end
    end
  end

  // Walk counter and copy pipeline
  assign copy_rd = cmd_i.copy && !status_o.copy_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q <= '0;
      pend_q <= 1'b0;
    end else begin
      if (cmd_i.walk_clr) begin
        walk_q <= '0;
      end else if (cmd_i.walk_inc) begin
        walk_q <= walk_q + AW'(1);
      end
      pend_q <= copy_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_addr_q <= walk_q;
    if (cmd_i.accept) begin
      rd_ok_q <= rd_ok;
    end
  end

  // RAM ports: the copy write-back, the blank fill and a character put never overlap
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cell_addr(RW'(row_q), CW'(col_q));
    ram_wdata = {attr_q, character_i};
    if (pend_q) begin
      ram_we    = 1'b1;
      ram_waddr = pend_addr_q;
      ram_wdata = ram_rdata;
    end else if (cmd_i.fill) begin
      ram_we    = 1'b1;
      ram_waddr = walk_q;
      ram_wdata = tcce_pkg::BLANK_CELL;
    end else if (cmd_i.accept && put_print) begin
      ram_we = 1'b1;
    end
  end

  assign ram_re    = copy_rd || (cmd_i.accept && is_read && rd_ok);
  assign ram_raddr = cmd_i.copy ? AW'(walk_q + AW'(tcce_pkg::COLUMNS)) : read_address_i;

  tcce_ram #(
    .WIDTH (tcce_pkg::CELL_W),
    .DEPTH (tcce_pkg::CELL_COUNT)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((cmd_i.accept && !is_read) || cmd_i.rd_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      out_cursor_q <= cell_addr(row_x, col_x);
      out_data_q   <= '0;
    end else if (cmd_i.rd_load) begin
      out_data_q <= rd_ok_q ? ram_rdata : '0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign cursor_location_o = out_cursor_q;
  assign read_data_o       = out_data_q;

  assign status_o.item_clear  = (mode_i == tcce_pkg::MODE_CLEAR);
  assign status_o.item_scroll = scroll;
  assign status_o.item_read   = is_read;
  assign status_o.copy_done   = (walk_q == AW'(tcce_pkg::COPY_CELLS));
  assign status_o.fill_done   = (walk_q == AW'(tcce_pkg::CELL_COUNT - 1));
  assign status_o.out_busy    = out_valid_q && !out_ready_i;

  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q < tcce_pkg::COL_W'(tcce_pkg::COLUMNS) && row_q < tcce_pkg::ROW_W'(tcce_pkg::ROWS))
    else $error("cursor outside the screen");

  a_no_write_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pend_q && (cmd_i.fill || cmd_i.accept)))
    else $error("copy write-back collides with another write");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accept && !is_read |=> out_valid_q)
    else $error("accepted item gave no result");

endmodule

// ===== rtl/core/tcce_ctrl.sv =====
module tcce_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tcce_pkg::status_t   status_i,
  output tcce_pkg::cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_READ   = 4'b0010,
    S_SCROLL = 4'b0100,
    S_FILL   = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   xfer;

  assign in_ready_o = (state_q == S_IDLE) && !status_i.out_busy;
  assign xfer       = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (xfer) begin
          cmd_o.accept   = 1'b1;
          cmd_o.walk_clr = 1'b1;
          if (status_i.item_clear) begin
            state_d = S_FILL;
          end else if (status_i.item_scroll) begin
            state_d = S_SCROLL;
          end else if (status_i.item_read) begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        cmd_o.rd_load = 1'b1;
        state_d       = S_IDLE;
      end
      S_SCROLL: begin
        cmd_o.copy = 1'b1;
        if (status_i.copy_done) begin
          state_d = S_FILL;
        end else begin
          cmd_o.walk_inc = 1'b1;
        end
      end
      S_FILL: begin
        cmd_o.fill = 1'b1;
        if (status_i.fill_done) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.walk_inc = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_read_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |-> $past(state_q) == S_IDLE)
    else $error("read load without an accepted read");

  a_scroll_to_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCROLL && status_i.copy_done |=> state_q == S_FILL)
    else $error("scroll copy did not hand over to the blank fill");

  a_fill_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FILL && status_i.fill_done |=> state_q == S_IDLE)
    else $error("fill did not end at the last cell");

endmodule

// ===== rtl/core/text_console_character_engine.sv =====
// Text console, 80 columns by 25 rows of 16-bit cells (attribute in the high
// byte, character in the low byte) plus a cursor. Every item on the request
// channel gives exactly one transfer on the response channel carrying the
// linear cursor location (row*80+column) after the item, and for a read the
// addressed cell (zero for an address past the last cell, zero for any other
// mode). A put of a printable byte or a cursor move is done on acceptance; a
// read then loads its cell from the RAM. The cell store is a single RAM with
// one write and one registered read port, so the controller takes an item
// only when idle and no earlier result stalls. A put that runs the cursor
// past the last row scrolls: the RAM port copies each cell up by one row,
// one cell a cycle, and then blanks the last row. Clear blanks every cell,
// one a cycle. Scroll and clear write the fixed blank cell 0x0F20 whatever
// the attribute. The user must write the attribute register (reset 0x0F)
// through cfg_we_i/cfg_wdata_i only while the block is idle; not enforced.
// Cells are not cleared at reset: read only what has been written.
module text_console_character_engine (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tcce_pkg::ATTR_W-1:0] cfg_wdata_i,
  tcce_req_if.sink                    req_i,
  tcce_rsp_if.source                  rsp_o
);

  tcce_pkg::cmd_t    cmd;
  tcce_pkg::status_t status;

  // Sequencer: accept, read turnaround, scroll copy, blank fill
  tcce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Cursor, attribute, cell RAM and the result register
  tcce_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .mode_i            (req_i.mode),
    .character_i       (req_i.character),
    .read_address_i    (req_i.read_address),
    .out_ready_i       (rsp_o.ready),
    .cmd_i             (cmd),
    .status_o          (status),
    .out_valid_o       (rsp_o.valid),
    .cursor_location_o (rsp_o.cursor_location),
    .read_data_o       (rsp_o.read_data)
  );

endmodule
